FILE: rtl/pv2d_pkg.sv
// shared types and constants for the proxy v2 header decoder
// no dependencies; used by the interfaces and every module
package pv2d_pkg;

  localparam int SIG_BYTES = 12;
  localparam int HDR_BYTES = 28;
  localparam int POS_W     = 5;
  localparam int BYTE_W    = 8;
  localparam int NIB_W     = 4;
  localparam int LEN_W     = 16;
  localparam int ADDR_W    = 32;
  localparam int PORT_W    = 16;
  localparam int STAT_W    = 3;

  localparam logic [NIB_W-1:0] VERSION_2   = NIB_W'(2);
  localparam logic [NIB_W-1:0] CMD_LOCAL   = NIB_W'(0);
  localparam logic [NIB_W-1:0] CMD_PROXY   = NIB_W'(1);
  localparam logic [LEN_W-1:0] IPV4_LENGTH = LEN_W'(12);

  localparam logic [NIB_W-1:0] FAMILY_RESET   = NIB_W'(1);
  localparam logic [NIB_W-1:0] PROTOCOL_RESET = NIB_W'(1);

  typedef enum logic [0:0] {
    REG_FAMILY   = 1'b0,
    REG_PROTOCOL = 1'b1
  } reg_index_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PROXY        = 3'd0,
    ST_HEALTH       = 3'd1,
    ST_BAD_SIG      = 3'd2,
    ST_BAD_VERSION  = 3'd3,
    ST_BAD_COMMAND  = 3'd4,
    ST_BAD_FAMILY   = 3'd5,
    ST_BAD_PROTOCOL = 3'd6,
    ST_BAD_LENGTH   = 3'd7
  } status_t;

  // header as seen when its last byte is accepted
  typedef struct packed {
    logic              sig_ok;
    logic [BYTE_W-1:0] ver_cmd;
    logic [BYTE_W-1:0] fam_proto;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] from_addr;
    logic [ADDR_W-1:0] to_addr;
    logic [PORT_W-1:0] from_port;
    logic [PORT_W-1:0] to_port;
  } hdr_t;

  typedef struct packed {
    logic [NIB_W-1:0] family;
    logic [NIB_W-1:0] protocol;
  } cfg_t;

  // standard v2 signature, indexed by byte position
  function automatic logic [BYTE_W-1:0] sig_byte(input logic [3:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      4'd0:    b = 8'h0D;
      4'd1:    b = 8'h0A;
      4'd2:    b = 8'h0D;
      4'd3:    b = 8'h0A;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h0D;
      4'd6:    b = 8'h0A;
      4'd7:    b = 8'h51;
      4'd8:    b = 8'h55;
      4'd9:    b = 8'h49;
      4'd10:   b = 8'h54;
      4'd11:   b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/pv2d_ifs.sv
// valid/ready channel interfaces for header bytes and decoded results
// depends on pv2d_pkg for field widths
interface pv2d_byte_if;
  logic                         valid;
  logic                         ready;
  logic [pv2d_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface pv2d_result_if;
  logic                         valid;
  logic                         ready;
  logic [pv2d_pkg::STAT_W-1:0]  status;
  logic [pv2d_pkg::LEN_W-1:0]   address_length;
  logic [pv2d_pkg::ADDR_W-1:0]  source_address;
  logic [pv2d_pkg::ADDR_W-1:0]  destination_address;
  logic [pv2d_pkg::PORT_W-1:0]  source_port;
  logic [pv2d_pkg::PORT_W-1:0]  destination_port;

  modport source (output valid, output status, output address_length,
                  output source_address, output destination_address,
                  output source_port, output destination_port, input ready);
  modport sink   (input valid, input status, input address_length,
                  input source_address, input destination_address,
                  input source_port, input destination_port, output ready);
endinterface

FILE: rtl/pv2d_header_track.sv
// byte position counter, signature compare and big-endian field capture
// depends on pv2d_pkg
module pv2d_header_track (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [pv2d_pkg::BYTE_W-1:0] data_byte,
  output logic                        last,
  output pv2d_pkg::hdr_t              hdr
);
  import pv2d_pkg::*;

  localparam int FS0_W = 48;
  localparam int FS1_W = 56;

  logic [POS_W-1:0]  pos;
  logic              sig_ok;
  logic [BYTE_W-1:0] ver_cmd;
  logic [BYTE_W-1:0] fam_proto;
  logic [FS0_W-1:0]  fs0;
  logic [FS1_W-1:0]  fs1;
  logic [FS1_W+BYTE_W-1:0] fs1_full;

  assign last     = (pos == POS_W'(HDR_BYTES - 1));
  assign fs1_full = {fs1, data_byte};

  always_comb begin
    hdr.sig_ok    = sig_ok;
    hdr.ver_cmd   = ver_cmd;
    hdr.fam_proto = fam_proto;
    hdr.length    = fs0[FS0_W-1 -: LEN_W];
    hdr.from_addr = fs0[ADDR_W-1:0];
    hdr.to_addr   = fs1_full[FS1_W+BYTE_W-1 -: ADDR_W];
    hdr.from_port = fs1_full[2*PORT_W-1 -: PORT_W];
    hdr.to_port   = fs1_full[PORT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      sig_ok <= 1'b1;
    end else if (accept) begin
      if (last) begin
        pos    <= '0;
        sig_ok <= 1'b1;
      end else begin
        pos <= pos + POS_W'(1);
        if (pos < POS_W'(SIG_BYTES) && data_byte != sig_byte(pos[3:0])) begin
          sig_ok <= 1'b0;
        end
      end
    end
  end

  // payload capture, no reset: every byte is rewritten before use
  always_ff @(posedge clk) begin
    if (accept && !last) begin
      if (pos == POS_W'(SIG_BYTES)) begin
        ver_cmd <= data_byte;
      end else if (pos == POS_W'(SIG_BYTES + 1)) begin
        fam_proto <= data_byte;
      end else if (pos > POS_W'(SIG_BYTES + 1) && pos < POS_W'(SIG_BYTES + 8)) begin
        fs0 <= {fs0[FS0_W-BYTE_W-1:0], data_byte};
      end else if (pos >= POS_W'(SIG_BYTES + 8)) begin
        fs1 <= {fs1[FS1_W-BYTE_W-1:0], data_byte};
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(HDR_BYTES - 1))
    else $error("byte position past end of header");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> pos == '0 && sig_ok)
    else $error("header state not cleared after last byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(pos))
    else $error("byte position moved without an item");

endmodule

FILE: rtl/pv2d_result_stage.sv
// status checks and the result output register
// depends on pv2d_pkg
module pv2d_result_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  pv2d_pkg::hdr_t   hdr,
  input  pv2d_pkg::cfg_t   cfg,
  output logic             free,
  pv2d_result_if.source    result
);
  import pv2d_pkg::*;

  status_t           st;
  logic              valid;
  logic              valid_next;
  logic [NIB_W-1:0]  version;
  logic [NIB_W-1:0]  command;
  logic [NIB_W-1:0]  family;
  logic [NIB_W-1:0]  protocol;

  assign version  = hdr.ver_cmd[7:4];
  assign command  = hdr.ver_cmd[3:0];
  assign family   = hdr.fam_proto[7:4];
  assign protocol = hdr.fam_proto[3:0];

  // first failing check wins
  always_comb begin
    if (!hdr.sig_ok)                    st = ST_BAD_SIG;
    else if (version != VERSION_2)      st = ST_BAD_VERSION;
    else if (command == CMD_LOCAL)      st = ST_HEALTH;
    else if (command != CMD_PROXY)      st = ST_BAD_COMMAND;
    else if (family != cfg.family)      st = ST_BAD_FAMILY;
    else if (protocol != cfg.protocol)  st = ST_BAD_PROTOCOL;
    else if (hdr.length != IPV4_LENGTH) st = ST_BAD_LENGTH;
    else                                st = ST_PROXY;
  end

  assign free         = !valid || result.ready;
  assign valid_next   = take ? 1'b1 : (result.ready ? 1'b0 : valid);
  assign result.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.status              <= st;
      result.address_length      <= hdr.length;
      result.source_address      <= hdr.from_addr;
      result.destination_address <= hdr.to_addr;
      result.source_port         <= (st == ST_PROXY) ? hdr.from_port : '0;
      result.destination_port    <= (st == ST_PROXY) ? hdr.to_port : '0;
    end
  end

  a_ports_zero: assert property (@(posedge clk) disable iff (rst)
    valid && result.status != ST_PROXY |->
      result.source_port == '0 && result.destination_port == '0)
    else $error("ports not cleared on failing header");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    take |-> free)
    else $error("result overwritten before it was taken");

endmodule

FILE: rtl/proxy_v2_header_decoder_core.sv
// a result appears in the cycle after the last header byte is accepted
// one byte per cycle while not stalled; a header is 28 bytes, one result each
// input is stalled only while a finished result waits at the output
// reset (rst, synchronous, active high): position 0, signature check armed,
// no result pending, expected family and protocol both 1
module proxy_v2_header_decoder_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [pv2d_pkg::NIB_W-1:0] cfg_data,
  pv2d_byte_if.sink                  hdr_byte,
  pv2d_result_if.source              result
);
  import pv2d_pkg::*;

  cfg_t  cfg;
  hdr_t  hdr;
  logic  last;
  logic  free;
  logic  accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.family   <= FAMILY_RESET;
      cfg.protocol <= PROTOCOL_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_FAMILY:   cfg.family   <= cfg_data;
        REG_PROTOCOL: cfg.protocol <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign hdr_byte.ready = free;
  assign accept         = hdr_byte.valid && free;

  pv2d_header_track u_track (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (hdr_byte.data_byte),
    .last      (last),
    .hdr       (hdr)
  );

  pv2d_result_stage u_result (
    .clk    (clk),
    .rst    (rst),
    .take   (accept && last),
    .hdr    (hdr),
    .cfg    (cfg),
    .free   (free),
    .result (result)
  );

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !hdr_byte.ready |-> result.valid)
    else $error("input stalled with empty output");

  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> result.valid)
    else $error("last byte gave no result");

endmodule

FILE: test/pv2d_tb_pkg.sv
// scoreboard for the proxy v2 header decoder testbench: predicts decoded headers
// from accepted bytes and checks the decoder's results against them
// depends on pv2d_pkg for widths, status codes and register indexes
package pv2d_tb_pkg;
  import pv2d_pkg::*;

  localparam int HDR_W = 8 * HDR_BYTES;
  // standard v2 signature, byte 0 in the top bits
  localparam logic [8*SIG_BYTES-1:0] PROXY_SIG = 96'h0D0A0D0A000D0A515549540A;

  typedef struct {
    status_t           status;
    logic [LEN_W-1:0]  address_length;
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] destination_address;
    logic [PORT_W-1:0] source_port;
    logic [PORT_W-1:0] destination_port;
  } decoded_hdr_t;

  class header_scoreboard;
    logic [NIB_W-1:0]  family_cfg;
    logic [NIB_W-1:0]  protocol_cfg;
    logic [POS_W-1:0]  position;
    bit                sig_good;
    logic [BYTE_W-1:0] ver_cmd;
    logic [BYTE_W-1:0] fam_proto;
    logic [47:0]       lead_shift;  // length and source address
    logic [63:0]       tail_shift;  // destination address and both ports
    decoded_hdr_t      expected_headers[$];
    int                errors;
    int                headers_checked;
    int                status_count[8];

    function new();
      family_cfg      = FAMILY_RESET;
      protocol_cfg    = PROTOCOL_RESET;
      errors          = 0;
      headers_checked = 0;
      foreach (status_count[i]) status_count[i] = 0;
      clear_header();
    endfunction

    function void clear_header();
      position   = '0;
      sig_good   = 1'b1;
      ver_cmd    = '0;
      fam_proto  = '0;
      lead_shift = '0;
      tail_shift = '0;
    endfunction

    function void write_reg(reg_index_t idx, logic [NIB_W-1:0] value);
      case (idx)
        REG_FAMILY:   family_cfg = value;
        REG_PROTOCOL: protocol_cfg = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_headers.size();
    endfunction

    // first failing check wins
    function status_t header_status(logic [LEN_W-1:0] len);
      if (!sig_good) return ST_BAD_SIG;
      if (ver_cmd[7:4] != VERSION_2) return ST_BAD_VERSION;
      if (ver_cmd[3:0] == CMD_LOCAL) return ST_HEALTH;
      if (ver_cmd[3:0] != CMD_PROXY) return ST_BAD_COMMAND;
      if (fam_proto[7:4] != family_cfg) return ST_BAD_FAMILY;
      if (fam_proto[3:0] != protocol_cfg) return ST_BAD_PROTOCOL;
      if (len != IPV4_LENGTH) return ST_BAD_LENGTH;
      return ST_PROXY;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      decoded_hdr_t d;
      if (position < SIG_BYTES) begin
        if (b != PROXY_SIG[8*SIG_BYTES-1-8*int'(position) -: 8]) sig_good = 1'b0;
      end else if (position == SIG_BYTES) begin
        ver_cmd = b;
      end else if (position == SIG_BYTES + 1) begin
        fam_proto = b;
      end else if (position < SIG_BYTES + 8) begin
        lead_shift = {lead_shift[39:0], b};
      end else begin
        tail_shift = {tail_shift[55:0], b};
      end
      if (position == HDR_BYTES - 1) begin
        d.status              = header_status(lead_shift[47:32]);
        d.address_length      = lead_shift[47:32];
        d.source_address      = lead_shift[31:0];
        d.destination_address = tail_shift[63:32];
        // ports only go out on a good proxy header
        d.source_port         = (d.status == ST_PROXY) ? tail_shift[31:16] : '0;
        d.destination_port    = (d.status == ST_PROXY) ? tail_shift[15:0] : '0;
        expected_headers.insert(expected_headers.size(), d);
        clear_header();
      end else begin
        position = position + 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("mismatch in %s of header %0d: expected %h, got %h",
                   name, headers_checked, want, got);
      end
    endfunction

    function void check_header(decoded_hdr_t got);
      decoded_hdr_t want;
      if (expected_headers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with no header pending, status %0d", got.status);
        return;
      end
      want = expected_headers.pop_front();
      headers_checked++;
      status_count[want.status]++;
      compare_field("status", want.status, got.status);
      compare_field("address_length", want.address_length, got.address_length);
      compare_field("source_address", want.source_address, got.source_address);
      compare_field("destination_address", want.destination_address,
                    got.destination_address);
      compare_field("source_port", want.source_port, got.source_port);
      compare_field("destination_port", want.destination_port, got.destination_port);
    endfunction
  endclass

endpackage

FILE: test/proxy_v2_header_decoder_core_tb.sv
// top-level testbench for proxy_v2_header_decoder_core: directed and random
// header byte streams under several pacing modes and register settings
// depends on pv2d_pkg, pv2d_ifs and pv2d_tb_pkg
module proxy_v2_header_decoder_core_tb;
  import pv2d_pkg::*;
  import pv2d_tb_pkg::*;

  localparam int STUCK_LIMIT = 5000;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  reg_index_t       cfg_index;
  logic [NIB_W-1:0] cfg_data;

  pv2d_byte_if   hdr_if();
  pv2d_result_if res_if();

  proxy_v2_header_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hdr_byte  (hdr_if),
    .result    (res_if)
  );

  header_scoreboard sb = new();

  int               idle_pct;
  int               stall_pct;
  int               bytes_sent;
  int               stuck_cycles;
  logic [NIB_W-1:0] cur_family;
  logic [NIB_W-1:0] cur_protocol;
  decoded_hdr_t     seen_hdr;
  logic [HDR_W-1:0] hdr;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random back-pressure, changed on the falling edge
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      seen_hdr.status              = status_t'(res_if.status);
      seen_hdr.address_length      = res_if.address_length;
      seen_hdr.source_address      = res_if.source_address;
      seen_hdr.destination_address = res_if.destination_address;
      seen_hdr.source_port         = res_if.source_port;
      seen_hdr.destination_port    = res_if.destination_port;
      sb.check_header(seen_hdr);
    end
    if ((hdr_if.valid && hdr_if.ready) || (res_if.valid && res_if.ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", STUCK_LIMIT);
      $display("proxy_v2_header_decoder_core_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [HDR_W-1:0] build_header(
    input logic [BYTE_W-1:0] vc, input logic [BYTE_W-1:0] fp,
    input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] src,
    input logic [ADDR_W-1:0] dst, input logic [PORT_W-1:0] sp,
    input logic [PORT_W-1:0] dp);
    return {PROXY_SIG, vc, fp, len, src, dst, sp, dp};
  endfunction

  function automatic logic [HDR_W-1:0] break_sig(input logic [HDR_W-1:0] h,
                                                 input int pos, input logic [7:0] flip);
    logic [HDR_W-1:0] r;
    r = h;
    r[HDR_W-1-8*pos -: 8] = r[HDR_W-1-8*pos -: 8] ^ flip;
    return r;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      hdr_if.valid = 1'b0;
      @(negedge clk);
    end
    hdr_if.valid     = 1'b1;
    hdr_if.data_byte = b;
    @(posedge clk);
    while (!hdr_if.ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [HDR_W-1:0] h);
    for (int i = 0; i < HDR_BYTES; i++) send_byte(h[HDR_W-1-8*i -: 8]);
  endtask

  // hold the byte stream until every decoded header has come out
  task automatic wait_drained();
    @(negedge clk);
    hdr_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input reg_index_t idx, input logic [NIB_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    sb.write_reg(idx, value);
    if (idx == REG_FAMILY) cur_family = value;
    else cur_protocol = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly well-formed headers for the current setting, the rest broken or noise
  task automatic make_random_header(output logic [HDR_W-1:0] h);
    logic [BYTE_W-1:0] vc;
    logic [BYTE_W-1:0] fp;
    logic [LEN_W-1:0]  len;
    int                kind;
    vc   = {VERSION_2, CMD_PROXY};
    fp   = {cur_family, cur_protocol};
    len  = IPV4_LENGTH;
    kind = $urandom_range(0, 99);
    if (kind >= 50 && kind < 56) vc[3:0] = CMD_LOCAL;
    else if (kind >= 56 && kind < 62) vc[7:4] = 4'($urandom);
    else if (kind >= 62 && kind < 68) vc[3:0] = 4'($urandom);
    else if (kind >= 68 && kind < 74) fp[7:4] = 4'($urandom);
    else if (kind >= 74 && kind < 80) fp[3:0] = 4'($urandom);
    else if (kind >= 80 && kind < 86) len = 16'($urandom);
    h = build_header(vc, fp, len, $urandom, $urandom, 16'($urandom), 16'($urandom));
    if (kind >= 86 && kind < 93)
      h = break_sig(h, $urandom_range(0, SIG_BYTES - 1), 8'($urandom_range(1, 255)));
    else if (kind >= 93)
      h = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_FAMILY;
    cfg_data         = '0;
    hdr_if.valid     = 1'b0;
    hdr_if.data_byte = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    bytes_sent       = 0;
    stuck_cycles     = 0;
    cur_family       = FAMILY_RESET;
    cur_protocol     = PROTOCOL_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed headers with the reset setting
    send_header(build_header(8'h21, 8'h11, IPV4_LENGTH, '0, '0, '0, '0));
    send_header(build_header(8'h21, 8'h11, IPV4_LENGTH, '1, '1, '1, '1));
    send_header(build_header(8'h20, 8'h11, IPV4_LENGTH, $urandom, $urandom,
                             16'($urandom), 16'($urandom)));
    hdr = build_header(8'h21, 8'h11, IPV4_LENGTH, $urandom, $urandom, 16'h1234, 16'h5678);
    send_header(break_sig(hdr, 0, 8'hFF));
    send_header(break_sig(hdr, SIG_BYTES - 1, 8'h01));
    // bad signature hides a bad version
    send_header(break_sig(build_header(8'h11, 8'h11, IPV4_LENGTH, $urandom, $urandom,
                                       '1, '1), 4, 8'h80));
    send_header(build_header(8'h11, 8'h11, IPV4_LENGTH, $urandom, $urandom, '1, '1));
    send_header(build_header(8'hF1, 8'h11, IPV4_LENGTH, $urandom, $urandom, '1, '1));
    send_header(build_header(8'h2F, 8'h11, IPV4_LENGTH, $urandom, $urandom, '1, '1));
    send_header(build_header(8'h21, 8'h21, IPV4_LENGTH, $urandom, $urandom, '1, '1));
    send_header(build_header(8'h21, 8'h12, IPV4_LENGTH, $urandom, $urandom, '1, '1));
    send_header(build_header(8'h21, 8'h11, 16'hFFFF, $urandom, $urandom, '1, '1));
    send_header(build_header(8'h21, 8'h11, 16'h0000, $urandom, $urandom, '1, '1));
    send_header('0);
    send_header('1);

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          idle_pct = 0;  stall_pct = 0;
          write_cfg(REG_FAMILY, 4'h0);
          write_cfg(REG_PROTOCOL, 4'hF);
        end
        1: begin
          idle_pct = 63; stall_pct = 0;
          write_cfg(REG_FAMILY, 4'hF);
          write_cfg(REG_PROTOCOL, 4'h0);
        end
        2: begin
          idle_pct = 0;  stall_pct = 63;
          write_cfg(REG_FAMILY, 4'($urandom));
          write_cfg(REG_PROTOCOL, 4'($urandom));
        end
        default: begin
          idle_pct = 15; stall_pct = 15;
          write_cfg(REG_FAMILY, FAMILY_RESET);
          write_cfg(REG_PROTOCOL, PROTOCOL_RESET);
        end
      endcase
      for (int n = 0; n < 6; n++) begin
        if ($urandom_range(0, 7) == 0) wait_drained();
        make_random_header(hdr);
        send_header(hdr);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("covered %0d header bytes, %0d headers, four pacing modes, five settings",
             bytes_sent, sb.headers_checked);
    $display("status mix: ok %0d health %0d sig %0d ver %0d cmd %0d fam %0d proto %0d len %0d",
             sb.status_count[ST_PROXY], sb.status_count[ST_HEALTH],
             sb.status_count[ST_BAD_SIG], sb.status_count[ST_BAD_VERSION],
             sb.status_count[ST_BAD_COMMAND], sb.status_count[ST_BAD_FAMILY],
             sb.status_count[ST_BAD_PROTOCOL], sb.status_count[ST_BAD_LENGTH]);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("proxy_v2_header_decoder_core_tb: done, clean");
    else
      $display("proxy_v2_header_decoder_core_tb: done, errors");
    $finish;
  end

endmodule
